@@ hw/rtl/ihex2bin_pkg.sv @@
// Shared types, constants and helpers for the Intel HEX to binary image core.
`timescale 1ns / 1ps
package ihex2bin_pkg;

	localparam int IMAGE_BYTES_DEF = 32768;

	localparam int CHAR_W   = 8;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 15;
	localparam int OFS_W    = 16;
	localparam int STATUS_W = 3;
	localparam int SIZE_W   = 16;
	localparam int POS_W    = 10;
	localparam int NIB_W    = 4;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [POS_W-1:0] REC_HDR_CHARS  = POS_W'(10);
	localparam logic [POS_W-1:0] REC_DATA_START = POS_W'(8);

	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] KIND_DATA  = 8'h00;
	localparam logic [BYTE_W-1:0] KIND_EOF   = 8'h01;
	localparam logic [BYTE_W-1:0] KIND_ULBA  = 8'h04;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_TRUNC = 3'd3,
		ST_UPPER = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FIN_END,
		FIN_RANGE,
		FIN_TRUNC,
		FIN_UPPER
	} fin_kind_t;

	// one parsed event: an optional byte write followed by an optional file end
	typedef struct packed {
		logic              wr;
		logic [OFS_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
		logic              fin;
		fin_kind_t         kind;
	} op_t;

	function automatic logic [NIB_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
		logic [NIB_W-1:0] n;
		case (c) inside
			[8'h30:8'h39]: n = c[NIB_W-1:0];
			[8'h41:8'h46], [8'h61:8'h66]: n = c[NIB_W-1:0] + 4'd9;
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

@@ hw/rtl/ihex2bin_char_if.sv @@
// Character input channel: valid/ready handshake with one HEX text character.
`timescale 1ns / 1ps
interface ihex2bin_char_if;
	import ihex2bin_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] hex_char;
	logic              last_char;

	modport source (output valid, output hex_char, output last_char, input ready);
	modport sink   (input valid, input hex_char, input last_char, output ready);
endinterface

@@ hw/rtl/ihex2bin_res_if.sv @@
// Result output channel: valid/ready handshake with one image write or file end.
`timescale 1ns / 1ps
interface ihex2bin_res_if;
	import ihex2bin_pkg::*;

	logic                valid;
	logic                ready;
	logic                write_valid;
	logic [ADDR_W-1:0]   write_addr;
	logic [BYTE_W-1:0]   write_byte;
	logic                done_res;
	logic [STATUS_W-1:0] status;
	logic [SIZE_W-1:0]   image_size;

	modport source (
		output valid, output write_valid, output write_addr, output write_byte,
		output done_res, output status, output image_size, input ready
	);
	modport sink (
		input valid, input write_valid, input write_addr, input write_byte,
		input done_res, input status, input image_size, output ready
	);
endinterface

@@ hw/rtl/ihex2bin_front.sv @@
// Record parser: tracks position inside a HEX record and emits write/end events.
`timescale 1ns / 1ps
module ihex2bin_front #(
	parameter int IMAGE_BYTES = ihex2bin_pkg::IMAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	ihex2bin_char_if.sink       char_in,
	output ihex2bin_pkg::op_t   op,
	output logic                op_valid,
	input  logic                op_ready
);
	import ihex2bin_pkg::*;

	logic              phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d;
	logic [OFS_W-1:0]  ofs_q, ofs_d;
	logic [BYTE_W-1:0] kind_q, kind_d;
	logic [NIB_W-1:0]  hn_q, hn_d;
	logic [OFS_W-1:0]  upper_q, upper_d;
	logic              stopped_q;

	logic [POS_W-1:0]  pos_n;
	logic [NIB_W-1:0]  nib;
	logic [BYTE_W-1:0] v;
	logic [POS_W-2:0]  b;
	logic [POS_W-2:0]  d;
	logic [OFS_W-1:0]  dest;
	logic              in_range;
	logic [OFS_W-1:0]  upper_n;
	logic [POS_W-1:0]  rec_len;
	logic [POS_W-1:0]  trunc_lim;
	logic              wr;
	logic              fin;
	fin_kind_t         fin_kind;
	logic              xfer;

	assign pos_n    = pos_q + POS_W'(1);
	assign nib      = nibble_of(char_in.hex_char);
	assign v        = {hn_q, nib};
	assign b        = pos_n[POS_W-1:1] - (POS_W-1)'(1);
	assign d        = b - (POS_W-1)'(4);
	assign dest     = ofs_q + OFS_W'(d);
	assign in_range = {1'b0, dest} < (OFS_W+1)'(IMAGE_BYTES);
	assign upper_n  = {upper_q[BYTE_W-1:0], v};

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		ofs_d    = ofs_q;
		kind_d   = kind_q;
		hn_d     = hn_q;
		upper_d  = upper_q;
		wr       = 1'b0;
		fin      = 1'b0;
		fin_kind = FIN_END;
		if (!phase_q) begin
			if (char_in.hex_char == CHAR_COLON) begin
				phase_d = 1'b1;
				pos_d   = '0;
			end
		end else begin
			pos_d = pos_n;
			if (pos_n[0]) begin
				hn_d = nib;
			end else begin
				case (b)
					9'd0: cnt_d = v;
					9'd1: ofs_d = {v, ofs_q[BYTE_W-1:0]};
					9'd2: ofs_d = {ofs_q[OFS_W-1:BYTE_W], v};
					9'd3: begin
						kind_d = v;
						if (v == KIND_EOF) begin
							fin      = 1'b1;
							fin_kind = FIN_END;
						end
					end
					default: begin
						if (kind_q == KIND_DATA && d < {1'b0, cnt_q}) begin
							if (in_range) begin
								wr = 1'b1;
							end else begin
								fin      = 1'b1;
								fin_kind = FIN_RANGE;
							end
						end else if (kind_q == KIND_ULBA && cnt_q == 8'd2 && d < 9'd2) begin
							upper_d = upper_n;
							if (d == 9'd1 && upper_n != '0) begin
								fin      = 1'b1;
								fin_kind = FIN_UPPER;
							end
						end
					end
				endcase
			end
			if (!fin && pos_n >= rec_len) begin
				phase_d = 1'b0;
			end
		end
		if (!fin && char_in.last_char) begin
			fin = 1'b1;
			if (phase_d && pos_d >= REC_HDR_CHARS && kind_d == KIND_DATA && pos_d < trunc_lim) begin
				fin_kind = FIN_TRUNC;
			end else begin
				fin_kind = FIN_END;
			end
		end
	end

	assign rec_len   = REC_HDR_CHARS + POS_W'({cnt_d, 1'b0});
	assign trunc_lim = REC_DATA_START + POS_W'({cnt_d, 1'b0});

	assign char_in.ready = op_ready;
	assign xfer          = char_in.valid && op_ready;

	assign op_valid = char_in.valid && !stopped_q && (wr || fin);
	assign op.wr    = wr;
	assign op.addr  = dest;
	assign op.data  = v;
	assign op.fin   = fin;
	assign op.kind  = fin_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			pos_q     <= '0;
			cnt_q     <= '0;
			ofs_q     <= '0;
			kind_q    <= '0;
			hn_q      <= '0;
			upper_q   <= '0;
			stopped_q <= 1'b0;
		end else if (xfer) begin
			if (char_in.last_char) begin
				phase_q   <= 1'b0;
				pos_q     <= '0;
				cnt_q     <= '0;
				ofs_q     <= '0;
				kind_q    <= '0;
				hn_q      <= '0;
				upper_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				cnt_q     <= cnt_d;
				ofs_q     <= ofs_d;
				kind_q    <= kind_d;
				hn_q      <= hn_d;
				upper_q   <= upper_d;
				stopped_q <= fin;
			end
		end
	end

endmodule

@@ hw/rtl/ihex2bin_queue.sv @@
// Short FIFO of parsed events between the parser and the result stage.
`timescale 1ns / 1ps
module ihex2bin_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ihex2bin_pkg::op_t push_op,
	input  logic              push_valid,
	output logic              push_ready,
	output ihex2bin_pkg::op_t pop_op,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import ihex2bin_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ hw/rtl/ihex2bin_back.sv @@
// Result stage: tracks the image end, splits events into write and final results.
`timescale 1ns / 1ps
module ihex2bin_back #(
	parameter int IMAGE_BYTES = ihex2bin_pkg::IMAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ihex2bin_pkg::op_t op,
	input  logic              op_valid,
	output logic              op_ready,
	ihex2bin_res_if.source    res_out
);
	import ihex2bin_pkg::*;

	localparam int END_W = $clog2(IMAGE_BYTES + 1);

	logic              out_valid_q;
	logic              pend_q;
	fin_kind_t         pend_kind_q;
	logic [END_W-1:0]  end_q;

	logic              wv_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] byte_q;
	logic              done_q;
	status_t           status_q;
	logic [SIZE_W-1:0] size_q;

	logic              can_load;
	logic              load_fin;
	logic              load_wr;
	fin_kind_t         fin_kind;
	status_t           fin_status;
	logic [SIZE_W-1:0] fin_size;
	logic [SIZE_W:0]   end_wide;
	logic [END_W-1:0]  wr_end;

	assign can_load = !out_valid_q || res_out.ready;
	assign op_ready = can_load && !pend_q;
	assign load_wr  = op_ready && op_valid && op.wr;
	assign load_fin = can_load && (pend_q || (op_valid && !op.wr && op.fin));
	assign fin_kind = pend_q ? pend_kind_q : op.kind;
	assign end_wide = (SIZE_W+1)'(end_q);
	assign wr_end   = END_W'({1'b0, op.addr} + (OFS_W+1)'(1));

	always_comb begin
		fin_size = end_wide[SIZE_W] ? '1 : end_wide[SIZE_W-1:0];
		case (fin_kind)
			FIN_RANGE: fin_status = ST_RANGE;
			FIN_TRUNC: fin_status = ST_TRUNC;
			FIN_UPPER: begin
				fin_status = ST_UPPER;
				fin_size   = '0;
			end
			default:   fin_status = (end_q != '0) ? ST_OK : ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			pend_kind_q <= FIN_END;
			end_q       <= '0;
		end else if (can_load) begin
			out_valid_q <= load_wr || load_fin;
			if (load_fin) begin
				pend_q <= 1'b0;
				end_q  <= '0;
			end else if (load_wr) begin
				pend_q      <= op.fin;
				pend_kind_q <= op.kind;
				if (wr_end > end_q) begin
					end_q <= wr_end;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_fin) begin
			wv_q     <= 1'b0;
			addr_q   <= '0;
			byte_q   <= '0;
			done_q   <= 1'b1;
			status_q <= fin_status;
			size_q   <= fin_size;
		end else if (load_wr) begin
			wv_q     <= 1'b1;
			addr_q   <= op.addr[ADDR_W-1:0];
			byte_q   <= op.data;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			size_q   <= '0;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.write_valid = wv_q;
	assign res_out.write_addr  = addr_q;
	assign res_out.write_byte  = byte_q;
	assign res_out.done_res    = done_q;
	assign res_out.status      = status_q;
	assign res_out.image_size  = size_q;

endmodule

@@ hw/rtl/intel_hex_to_binary_image_core.sv @@
// Top level of the Intel HEX to binary image core.
// Takes one ASCII character of Intel HEX text per transfer and gives byte writes for an
// image memory that the user pre-fills with 0xFF, followed by one final result per file
// with status and image size (highest written address plus one, 0 for ST_UPPER).
// Checksums are not checked; characters that are not hex digits read as zero. A character
// is taken every cycle while the event queue has room; one that both completes a
// data byte and ends the file gives two results, which the result stage sends one after
// the other while a four-entry event queue keeps the character side moving. The first
// result of a character is registered in the event queue and then in the result stage
// before it is valid.
`timescale 1ns / 1ps
module intel_hex_to_binary_image_core #(
	parameter int IMAGE_BYTES = ihex2bin_pkg::IMAGE_BYTES_DEF
) (
	input logic            clk,
	input logic            arst_n,
	ihex2bin_char_if.sink  char_in,
	ihex2bin_res_if.source res_out
);
	import ihex2bin_pkg::*;

	op_t  front_op;
	logic front_valid;
	logic front_ready;
	op_t  back_op;
	logic back_valid;
	logic back_ready;

	ihex2bin_front #(
		.IMAGE_BYTES(IMAGE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	ihex2bin_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (front_op),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_op     (back_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	ihex2bin_back #(
		.IMAGE_BYTES(IMAGE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.res_out  (res_out)
	);

endmodule
